FILE: design/hsfl_pkg.sv
// Package for the scaled HMM forward-likelihood block.
// Holds sizes, formats, command and state types used by all modules but the RAM.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hsfl_pkg;

  // Model sizes and probability format
  localparam int MAX_STATES     = 16;
  localparam int MAX_SYMBOLS    = 64;
  localparam int PROB_FRAC_BITS = 15;

  // Field widths fixed by the interface
  localparam int REQ_W   = 2;
  localparam int ROW_W   = 4;
  localparam int COL_W   = 6;
  localparam int PROB_W  = 16;
  localparam int SYM_W   = 6;
  localparam int LOG_W   = 32;
  localparam int NST_W   = 5;
  localparam int NSYM_W  = 7;
  localparam int CFG_W   = 7;
  localparam int CFGA_W  = 1;

  // Derived internal widths
  localparam int ST_W    = $clog2(MAX_STATES);
  localparam int SI_W    = $clog2(MAX_SYMBOLS);
  localparam int TADDR_W = 2 * ST_W;
  localparam int EADDR_W = ST_W + SI_W;
  localparam int ACC_W   = 2 * PROB_W + ST_W;
  localparam int F_W     = ACC_W - PROB_FRAC_BITS;
  localparam int U_W     = PROB_W + F_W;
  localparam int TOT_W   = U_W + ST_W;
  localparam int MANT_W  = 31;
  localparam int CNT_W   = $clog2(TOT_W);
  localparam int L2_W    = 24;
  localparam int LNP_W   = L2_W + 32;

  localparam logic [PROB_W-1:0] ONE_PROB = PROB_W'(1) << PROB_FRAC_BITS;
  localparam logic [31:0]       LN2_Q32  = 32'd2977044472;
  localparam logic [LOG_W-1:0]  LOG_MIN  = {1'b1, {(LOG_W-1){1'b0}}};
  localparam logic [LOG_W-1:0]  LOG_MAX  = {1'b0, {(LOG_W-1){1'b1}}};

  // Request codes on the input channel
  typedef enum logic [REQ_W-1:0] {
    REQ_LD_TRANS = 2'd0,
    REQ_LD_EMIS  = 2'd1,
    REQ_LD_INIT  = 2'd2,
    REQ_OBS      = 2'd3
  } req_e;

  // Configuration register indexes
  typedef enum logic [CFGA_W-1:0] {
    CFG_NUM_STATES  = 1'b0,
    CFG_NUM_SYMBOLS = 1'b1
  } cfg_e;

  // Command kinds after classification
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_LD_TRANS,
    CMD_LD_EMIS,
    CMD_LD_INIT,
    CMD_OBS
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [EADDR_W-1:0]  addr;
    logic [PROB_W-1:0]   value;
    logic [SYM_W-1:0]    sym;
    logic                sym_ok;
    logic                start;
    logic [ST_W-1:0]     n_m1;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EREAD,
    ST_MAC,
    ST_UMUL,
    ST_UACC,
    ST_NINIT,
    ST_NSTEP,
    ST_NFIN,
    ST_LSHIFT,
    ST_LSQ,
    ST_LMUL,
    ST_LRND,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

FILE: design/hsfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hsfl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/hsfl_front.sv
// Front end: input handshake, configuration registers and item classification.
// Depends on hsfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsfl_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [hsfl_pkg::CFGA_W-1:0]   cfg_index_i,
  input  wire logic [hsfl_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [hsfl_pkg::REQ_W-1:0]    req_type_i,
  input  wire logic [hsfl_pkg::ROW_W-1:0]    row_index_i,
  input  wire logic [hsfl_pkg::COL_W-1:0]    col_index_i,
  input  wire logic [hsfl_pkg::PROB_W-1:0]   prob_value_i,
  input  wire logic [hsfl_pkg::SYM_W-1:0]    obs_symbol_i,
  input  wire logic                          seq_start_i,
  input  wire logic                          q_full_i,
  output logic                               push_o,
  output hsfl_pkg::cmd_t                     cmd_o
);
  import hsfl_pkg::*;

  logic [NST_W-1:0]  num_states_q;
  logic [NSYM_W-1:0] num_symbols_q;
  logic [NST_W-1:0]  n_eff;
  logic [NSYM_W-1:0] ns_eff;
  logic [PROB_W-1:0] pv_sat;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_states_q  <= NST_W'(MAX_STATES);
      num_symbols_q <= NSYM_W'(MAX_SYMBOLS);
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_index_i))
        CFG_NUM_STATES:  num_states_q  <= cfg_wdata_i[NST_W-1:0];
        CFG_NUM_SYMBOLS: num_symbols_q <= cfg_wdata_i[NSYM_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers to their usable ranges
  always_comb begin
    n_eff = num_states_q;
    if (num_states_q == '0) n_eff = NST_W'(1);
    else if (num_states_q > NST_W'(MAX_STATES)) n_eff = NST_W'(MAX_STATES);
    ns_eff = num_symbols_q;
    if (num_symbols_q == '0) ns_eff = NSYM_W'(1);
    else if (num_symbols_q > NSYM_W'(MAX_SYMBOLS)) ns_eff = NSYM_W'(MAX_SYMBOLS);
  end

  assign pv_sat     = (prob_value_i > ONE_PROB) ? ONE_PROB : prob_value_i;
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Classify the transaction into a back-end command
  always_comb begin
    cmd_o        = '0;
    cmd_o.kind   = CMD_NOP;
    cmd_o.value  = pv_sat;
    cmd_o.sym    = obs_symbol_i;
    cmd_o.start  = seq_start_i;
    cmd_o.sym_ok = {1'b0, obs_symbol_i} < ns_eff;
    cmd_o.n_m1   = ST_W'(n_eff - NST_W'(1));
    case (req_e'(req_type_i))
      REQ_LD_TRANS: begin
        // Every row index is in range; only the destination state can be out of range
        if (col_index_i < COL_W'(MAX_STATES)) begin
          cmd_o.kind = CMD_LD_TRANS;
          cmd_o.addr = EADDR_W'({row_index_i[ST_W-1:0], col_index_i[ST_W-1:0]});
        end
      end
      REQ_LD_EMIS: begin
        cmd_o.kind = CMD_LD_EMIS;
        cmd_o.addr = {row_index_i[ST_W-1:0], col_index_i[SI_W-1:0]};
      end
      REQ_LD_INIT: begin
        cmd_o.kind = CMD_LD_INIT;
        cmd_o.addr = EADDR_W'(row_index_i[ST_W-1:0]);
      end
      REQ_OBS: begin
        cmd_o.kind = CMD_OBS;
      end
      default: cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/hsfl_queue.sv
// Two-entry command queue between front end and back end.
// Depends on hsfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsfl_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire hsfl_pkg::cmd_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output hsfl_pkg::cmd_t      data_o
);
  import hsfl_pkg::*;

  cmd_t       mem_q [2];
  logic       wptr_q;
  logic       rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

`default_nettype wire

FILE: design/hsfl_back.sv
// Back end: table writes and the scaled forward step with divider and log unit.
// Depends on hsfl_pkg and hsfl_ram.
`timescale 1ns / 1ps
`default_nettype none

module hsfl_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        q_empty_i,
  input  wire hsfl_pkg::cmd_t              cmd_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [hsfl_pkg::LOG_W-1:0]       log_likelihood_o,
  output logic [hsfl_pkg::LOG_W-1:0]       step_log_scale_o,
  output logic                             underflow_o
);
  import hsfl_pkg::*;

  state_e state_q, state_d;

  // Current observation
  logic [SYM_W-1:0] sym_q;
  logic             sym_ok_q;
  logic             start_q;
  logic [ST_W-1:0]  n_m1_q;
  logic [ST_W-1:0]  j_q;

  // Probability state and step products
  logic [PROB_W-1:0] alpha_q [MAX_STATES];
  logic [PROB_W-1:0] init_q  [MAX_STATES];
  logic [U_W-1:0]    u_q     [MAX_STATES];

  // MAC pipeline
  logic [ST_W:0]       k_q;
  logic [ST_W-1:0]     k1_q;
  logic                v1_q, v2_q;
  logic [2*PROB_W-1:0] prod_q;
  logic [ACC_W-1:0]    acc_q;
  logic [F_W-1:0]      f_q;
  logic [U_W-1:0]      uprod_q;
  logic [TOT_W-1:0]    total_q;
  logic [TOT_W:0]      total_nx;
  logic                issue_v;
  logic                mac_done;

  // Divider
  logic [TOT_W:0]    r_q;
  logic [TOT_W:0]    r2;
  logic [PROB_W-1:0] qt_q;
  logic [PROB_W-1:0] qfin;
  logic [3:0]        it_q;

  // Log unit
  logic [TOT_W-1:0]    x_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [MANT_W-1:0]   m_q;
  logic [2*MANT_W-1:0] msq;
  logic [15:0]         frac_q;
  logic signed [7:0]   expo;
  logic [L2_W-1:0]     l2;
  logic [L2_W-1:0]     mag;
  logic [LNP_W-1:0]    lnp_q;
  logic                neg_q;
  logic [L2_W-1:0]     rnd;
  logic [LOG_W-1:0]    step_q;
  logic                uf_q;

  // Result and output register
  logic [LOG_W-1:0] run_q;
  logic [LOG_W-1:0] run_base;
  logic [LOG_W:0]   run_sum;
  logic [LOG_W-1:0] run_new;
  logic             out_valid_q;
  logic [LOG_W-1:0] ll_q, sls_q;
  logic             ufo_q;
  logic             out_free;

  // RAM ports
  logic                trans_we, emis_we, trans_re, emis_re;
  logic [TADDR_W-1:0]  trans_raddr;
  logic [EADDR_W-1:0]  emis_raddr;
  logic [PROB_W-1:0]   trans_rdata, emis_rdata;
  logic [PROB_W-1:0]   b_val;

  hsfl_ram #(.WIDTH(PROB_W), .DEPTH(MAX_STATES * MAX_STATES)) u_trans (
    .clk_i   (clk_i),
    .we_i    (trans_we),
    .waddr_i (cmd_i.addr[TADDR_W-1:0]),
    .wdata_i (cmd_i.value),
    .re_i    (trans_re),
    .raddr_i (trans_raddr),
    .rdata_o (trans_rdata)
  );

  hsfl_ram #(.WIDTH(PROB_W), .DEPTH(MAX_STATES * MAX_SYMBOLS)) u_emis (
    .clk_i   (clk_i),
    .we_i    (emis_we),
    .waddr_i (cmd_i.addr),
    .wdata_i (cmd_i.value),
    .re_i    (emis_re),
    .raddr_i (emis_raddr),
    .rdata_o (emis_rdata)
  );

  // Shared combinational terms
  assign issue_v  = (state_q == ST_MAC) && (k_q <= {1'b0, n_m1_q});
  assign mac_done = (state_q == ST_MAC) && !issue_v && !v1_q && !v2_q;
  assign total_nx = {1'b0, total_q} + (TOT_W + 1)'(uprod_q);
  assign r2       = {r_q[TOT_W-1:0], 1'b0};
  assign qfin     = qt_q + PROB_W'(r2 >= {1'b0, total_q});
  assign msq      = m_q * m_q;
  assign expo     = 8'(TOT_W - 1) - 8'(cnt_q) - 8'(2 * PROB_FRAC_BITS);
  assign l2       = {expo, frac_q};
  assign mag      = l2[L2_W-1] ? (~l2 + L2_W'(1)) : l2;
  assign rnd      = L2_W'((lnp_q + LNP_W'(64'h8000_0000)) >> 32);
  assign b_val    = sym_ok_q ? emis_rdata : '0;
  assign out_free = !out_valid_q || out_ready_i;
  assign run_base = start_q ? '0 : run_q;
  assign run_sum  = {run_base[LOG_W-1], run_base} + {step_q[LOG_W-1], step_q};
  always_comb begin
    if (uf_q) run_new = LOG_MIN;
    else if (run_sum[LOG_W] != run_sum[LOG_W-1]) run_new = run_sum[LOG_W] ? LOG_MIN : LOG_MAX;
    else run_new = run_sum[LOG_W-1:0];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (!q_empty_i && cmd_i.kind == CMD_OBS) state_d = ST_EREAD;
      ST_EREAD:  state_d = start_q ? ST_UMUL : ST_MAC;
      ST_MAC:    if (mac_done) state_d = ST_UMUL;
      ST_UMUL:   state_d = ST_UACC;
      ST_UACC: begin
        if (j_q != n_m1_q) state_d = ST_EREAD;
        else if (total_nx == '0) state_d = ST_DONE;
        else state_d = ST_NINIT;
      end
      ST_NINIT:  state_d = ST_NSTEP;
      ST_NSTEP:  if (it_q == 4'(PROB_FRAC_BITS - 1)) state_d = ST_NFIN;
      ST_NFIN:   state_d = (j_q == n_m1_q) ? ST_LSHIFT : ST_NINIT;
      ST_LSHIFT: if (x_q[TOT_W-1]) state_d = ST_LSQ;
      ST_LSQ:    if (it_q == 4'd15) state_d = ST_LMUL;
      ST_LMUL:   state_d = ST_LRND;
      ST_LRND:   state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop_o       = 1'b0;
    trans_we    = 1'b0;
    emis_we     = 1'b0;
    trans_re    = issue_v;
    emis_re     = 1'b0;
    trans_raddr = {k_q[ST_W-1:0], j_q};
    emis_raddr  = {j_q, sym_q[SI_W-1:0]};
    case (state_q)
      ST_IDLE: begin
        pop_o    = !q_empty_i;
        trans_we = !q_empty_i && cmd_i.kind == CMD_LD_TRANS;
        emis_we  = !q_empty_i && cmd_i.kind == CMD_LD_EMIS;
      end
      ST_EREAD: emis_re = 1'b1;
      default: ;
    endcase
  end

  // Initial table, written only by loads
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && !q_empty_i && cmd_i.kind == CMD_LD_INIT) begin
      init_q[cmd_i.addr[ST_W-1:0]] <= cmd_i.value;
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk_i) begin
    k1_q   <= k_q[ST_W-1:0];
    prod_q <= trans_rdata * alpha_q[k1_q];
    case (state_q)
      ST_IDLE: begin
        sym_q    <= cmd_i.sym;
        sym_ok_q <= cmd_i.sym_ok;
        start_q  <= cmd_i.start;
        n_m1_q   <= cmd_i.n_m1;
        j_q      <= '0;
        total_q  <= '0;
      end
      ST_EREAD: begin
        acc_q <= '0;
        f_q   <= F_W'(init_q[j_q]);
      end
      ST_MAC: begin
        if (v2_q) acc_q <= acc_q + ACC_W'(prod_q);
        if (mac_done) begin
          f_q <= F_W'((acc_q + ACC_W'(1 << (PROB_FRAC_BITS - 1))) >> PROB_FRAC_BITS);
        end
      end
      ST_UMUL: uprod_q <= b_val * f_q;
      ST_UACC: begin
        u_q[j_q] <= uprod_q;
        total_q  <= total_nx[TOT_W-1:0];
        if (j_q != n_m1_q) j_q <= j_q + ST_W'(1);
        else j_q <= '0;
      end
      ST_NINIT: begin
        r_q  <= (TOT_W + 1)'(u_q[j_q]);
        qt_q <= '0;
      end
      ST_NSTEP: begin
        if (r2 >= {1'b0, total_q}) begin
          r_q  <= r2 - {1'b0, total_q};
          qt_q <= {qt_q[PROB_W-2:0], 1'b1};
        end else begin
          r_q  <= r2;
          qt_q <= {qt_q[PROB_W-2:0], 1'b0};
        end
      end
      ST_NFIN: begin
        j_q   <= j_q + ST_W'(1);
        x_q   <= total_q;
        cnt_q <= '0;
      end
      ST_LSHIFT: begin
        if (x_q[TOT_W-1]) begin
          m_q    <= x_q[TOT_W-1 -: MANT_W];
          frac_q <= '0;
        end else begin
          x_q   <= {x_q[TOT_W-2:0], 1'b0};
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      ST_LSQ: begin
        // Square the mantissa; an overflow past 2.0 yields the next fraction bit
        if (msq[61]) begin
          m_q                <= msq[61:31];
          frac_q[4'd15-it_q] <= 1'b1;
        end else begin
          m_q <= msq[60:30];
        end
      end
      ST_LMUL: begin
        neg_q <= l2[L2_W-1];
        lnp_q <= LNP_W'(mag) * LNP_W'(LN2_Q32);
      end
      ST_LRND: step_q <= neg_q ? LOG_W'(~LOG_W'(rnd) + LOG_W'(1)) : LOG_W'(rnd);
      default: ;
    endcase
    if (state_q == ST_UACC && j_q == n_m1_q && total_nx == '0) begin
      step_q <= LOG_MIN;
    end
    if (state_q == ST_DONE && out_free) begin
      ll_q  <= run_new;
      sls_q <= step_q;
      ufo_q <= uf_q;
    end
  end

  // Control state, MAC pipeline flags, state probabilities and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      it_q        <= '0;
      uf_q        <= 1'b0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_STATES; i++) alpha_q[i] <= '0;
    end else begin
      state_q <= state_d;
      v1_q    <= issue_v;
      v2_q    <= v1_q;
      if (state_q == ST_EREAD) k_q <= '0;
      else if (issue_v) k_q <= k_q + (ST_W + 1)'(1);
      if (state_q == ST_IDLE) uf_q <= 1'b0;
      // Iteration counter for divider and log unit
      if (state_q == ST_NINIT || (state_q == ST_LSHIFT && x_q[TOT_W-1])) it_q <= '0;
      else if (state_q == ST_NSTEP || state_q == ST_LSQ) it_q <= it_q + 4'd1;
      // All probabilities restart from zero once every product is formed
      if (state_q == ST_UACC && j_q == n_m1_q) begin
        for (int i = 0; i < MAX_STATES; i++) alpha_q[i] <= '0;
        if (total_nx == '0) uf_q <= 1'b1;
      end
      if (state_q == ST_NFIN) alpha_q[j_q] <= qfin;
      if (state_q == ST_DONE && out_free) begin
        run_q       <= run_new;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign log_likelihood_o = ll_q;
  assign step_log_scale_o = sls_q;
  assign underflow_o      = ufo_q;

`ifndef ASSERT_OFF
  // MAC pipeline is drained whenever the sequencer is idle
  a_mac_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!v1_q && !v2_q))
    else $error("MAC pipeline busy while idle");

  // A normalized probability never exceeds one
  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NFIN) |-> (qfin <= ONE_PROB))
    else $error("normalized probability above one");

  // Log mantissa stays in [1, 2) while squaring
  a_mant_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LSQ) |-> m_q[MANT_W-1])
    else $error("log mantissa not normalized");

  // Underflow is reported only with the saturated log scale
  a_uf_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && uf_q) |-> (step_q == LOG_MIN))
    else $error("underflow without saturated step");
`endif

endmodule

`default_nettype wire

FILE: design/hmm_scaled_forward_likelihood.sv
// Top level of the scaled HMM forward-likelihood block.
// Depends on hsfl_pkg, hsfl_front, hsfl_queue, hsfl_back.
//
// Load transactions write the transition, emission and initial tables; the back
// end takes them while idle. An observation with N states in use forms the
// transition sums with one multiply-accumulate per cycle through a pipeline of
// RAM read, product register and accumulator (skipped on the first symbol of a
// sequence, which starts from the initial table), then uses the bit-serial
// normalizing divider on each state and a leading-one search plus 16 squarings
// for the log. A two-entry command queue lets the input side keep accepting
// while the back end works or a result waits in the output register. Log
// outputs are Q16.16.
`timescale 1ns / 1ps
`default_nettype none

module hmm_scaled_forward_likelihood (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [hsfl_pkg::CFGA_W-1:0]   cfg_index_i,
  input  wire logic [hsfl_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [hsfl_pkg::REQ_W-1:0]    req_type_i,
  input  wire logic [hsfl_pkg::ROW_W-1:0]    row_index_i,
  input  wire logic [hsfl_pkg::COL_W-1:0]    col_index_i,
  input  wire logic [hsfl_pkg::PROB_W-1:0]   prob_value_i,
  input  wire logic [hsfl_pkg::SYM_W-1:0]    obs_symbol_i,
  input  wire logic                          seq_start_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [hsfl_pkg::LOG_W-1:0]  log_likelihood_o,
  output logic signed [hsfl_pkg::LOG_W-1:0]  step_log_scale_o,
  output logic                               underflow_o
);
  import hsfl_pkg::*;

  cmd_t             push_cmd, pop_cmd;
  logic             push, pop, q_full, q_empty;
  logic [LOG_W-1:0] ll, sls;

  // Accept and classify
  hsfl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .row_index_i  (row_index_i),
    .col_index_i  (col_index_i),
    .prob_value_i (prob_value_i),
    .obs_symbol_i (obs_symbol_i),
    .seq_start_i  (seq_start_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  // Decoupling queue
  hsfl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .data_o  (pop_cmd)
  );

  // Table writes and forward step
  hsfl_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .cmd_i            (pop_cmd),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .log_likelihood_o (ll),
    .step_log_scale_o (sls),
    .underflow_o      (underflow_o)
  );

  assign log_likelihood_o = $signed(ll);
  assign step_log_scale_o = $signed(sls);

endmodule

`default_nettype wire
